// ===== design/rhh_pkg.sv =====
// ============================================================================
// rhh_pkg - shared types and constants of the Robin Hood hash table
// Slot layout, store request and response groups, status and mode codes.
// ============================================================================
package rhh_pkg;

    localparam int unsigned CAPACITY = 64;
    localparam int unsigned ADDR_W   = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned DIST_W   = ADDR_W;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned PAY_W    = 32;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STAT_W   = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FOUND    = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  pay;
        logic [DIST_W-1:0] distance;
    } t_slot;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_slot             wr_slot;
        logic              occ_set;
        logic              occ_clr;
        logic [ADDR_W-1:0] occ_addr;
    } t_store_req;

    typedef struct packed {
        logic  occ;
        t_slot slot;
    } t_store_rsp;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [PAY_W-1:0]  found_payload;
        logic [CNT_W-1:0]  live_count;
    } t_result;

endpackage

// ===== design/rhh_store.sv =====
// ============================================================================
// rhh_store - slot memory and occupancy flags
// One write and one registered read per cycle; occupancy kept in flip-flops.
// ============================================================================
module rhh_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rhh_pkg::t_store_req i_req,
    output rhh_pkg::t_store_rsp o_rsp
);
    import rhh_pkg::*;

    t_slot                mem [CAPACITY];
    logic [CAPACITY-1:0]  r_occ;
    t_slot                r_rd_slot;
    logic                 r_rd_occ;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_slot;
        end
        if (i_req.rd_en) begin
            r_rd_slot <= mem[i_req.rd_addr];
            r_rd_occ  <= r_occ[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_req.occ_set) begin
            r_occ[i_req.occ_addr] <= 1'b1;
        end else if (i_req.occ_clr) begin
            r_occ[i_req.occ_addr] <= 1'b0;
        end
    end

    assign o_rsp.occ  = r_rd_occ;
    assign o_rsp.slot = r_rd_slot;

endmodule

// ===== design/rhh_ctrl.sv =====
// ============================================================================
// rhh_ctrl - probe sequencer of the hash table
// Locate, Robin Hood insert walk and backward-shift remove over one read port.
// ============================================================================
module rhh_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rhh_pkg::MODE_W-1:0] i_mode,
    input  logic [rhh_pkg::KEY_W-1:0]  i_key,
    input  logic [rhh_pkg::PAY_W-1:0]  i_pay,
    output rhh_pkg::t_result           o_res,
    input  logic                       i_res_take,
    output rhh_pkg::t_store_req        o_req,
    input  rhh_pkg::t_store_rsp        i_rsp
);
    import rhh_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LRD  = 8'b0000_0010,
        S_LCMP = 8'b0000_0100,
        S_IRD  = 8'b0000_1000,
        S_ICMP = 8'b0001_0000,
        S_RRD  = 8'b0010_0000,
        S_RCMP = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_ckey, n_ckey;
    logic [PAY_W-1:0]    r_cpay, n_cpay;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [ADDR_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]    r_count, n_count;
    t_status             r_status, n_status;
    logic [PAY_W-1:0]    r_found, n_found;

    logic [ADDR_W-1:0]   pos_next;
    logic                key_hit;
    logic                step_last;

    assign pos_next  = r_pos + ADDR_W'(1);
    assign key_hit   = i_rsp.occ && (i_rsp.slot.key == r_key);
    assign step_last = (r_step == ADDR_W'(CAPACITY - 1));

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_key    = r_key;
        n_ckey   = r_ckey;
        n_cpay   = r_cpay;
        n_dist   = r_dist;
        n_pos    = r_pos;
        n_step   = r_step;
        n_count  = r_count;
        n_status = r_status;
        n_found  = r_found;
        o_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_key   = i_key;
                    n_cpay  = i_pay;
                    n_pos   = i_key[ADDR_W-1:0];
                    n_step  = '0;
                    n_found = '0;
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_pos;
                n_state       = S_LCMP;
            end
            S_LCMP: begin
                if (key_hit) begin
                    unique case (r_mode)
                        MODE_INSERT: begin
                            n_status = ST_PRESENT;
                            n_state  = S_DONE;
                        end
                        MODE_REMOVE: begin
                            n_step  = '0;
                            n_state = S_RRD;
                        end
                        default: begin
                            n_found  = i_rsp.slot.pay;
                            n_status = ST_FOUND;
                            n_state  = S_DONE;
                        end
                    endcase
                end else if (!i_rsp.occ || step_last) begin
                    if (r_mode != MODE_INSERT) begin
                        n_status = ST_MISSING;
                        n_state  = S_DONE;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_pos   = r_key[ADDR_W-1:0];
                        n_dist  = '0;
                        n_ckey  = r_key;
                        n_state = S_IRD;
                    end
                end else begin
                    n_step  = r_step + ADDR_W'(1);
                    n_pos   = pos_next;
                    n_state = S_LRD;
                end
            end
            S_IRD: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_pos;
                n_state       = S_ICMP;
            end
            S_ICMP: begin
                o_req.wr_addr          = r_pos;
                o_req.wr_slot.key      = r_ckey;
                o_req.wr_slot.pay      = r_cpay;
                o_req.wr_slot.distance = r_dist;
                o_req.occ_addr         = r_pos;
                if (!i_rsp.occ) begin
                    o_req.wr_en   = 1'b1;
                    o_req.occ_set = 1'b1;
                    n_count       = r_count + CNT_W'(1);
                    n_status      = ST_INSERTED;
                    n_state       = S_DONE;
                end else begin
                    if (r_dist > i_rsp.slot.distance) begin
                        o_req.wr_en = 1'b1;
                        n_ckey      = i_rsp.slot.key;
                        n_cpay      = i_rsp.slot.pay;
                        n_dist      = i_rsp.slot.distance + DIST_W'(1);
                    end else begin
                        n_dist      = r_dist + DIST_W'(1);
                    end
                    n_pos   = pos_next;
                    n_state = S_IRD;
                end
            end
            S_RRD: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = pos_next;
                n_state       = S_RCMP;
            end
            S_RCMP: begin
                o_req.wr_addr          = r_pos;
                o_req.wr_slot.key      = i_rsp.slot.key;
                o_req.wr_slot.pay      = i_rsp.slot.pay;
                o_req.wr_slot.distance = i_rsp.slot.distance - DIST_W'(1);
                if (!i_rsp.occ || (i_rsp.slot.distance == '0)) begin
                    o_req.occ_clr  = 1'b1;
                    o_req.occ_addr = r_pos;
                    n_status       = ST_REMOVED;
                    n_state        = S_DONE;
                    if (r_count != '0) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end else begin
                    o_req.wr_en = 1'b1;
                    n_pos       = pos_next;
                    if (step_last) begin
                        o_req.occ_clr  = 1'b1;
                        o_req.occ_addr = pos_next;
                        n_status       = ST_REMOVED;
                        n_state        = S_DONE;
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end else begin
                        n_step  = r_step + ADDR_W'(1);
                        n_state = S_RRD;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_ckey   <= n_ckey;
        r_cpay   <= n_cpay;
        r_dist   <= n_dist;
        r_pos    <= n_pos;
        r_step   <= n_step;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_res.valid         = (r_state == S_DONE);
    assign o_res.status        = r_status;
    assign o_res.found_payload = r_found;
    assign o_res.live_count    = r_count;

endmodule

// ===== design/robin_hood_hash_table_top.sv =====
// ============================================================================
// robin_hood_hash_table_top - Robin Hood hash table with backward-shift delete
// Insert, remove and find on a 64-slot open-addressed table keyed by hash.
// ============================================================================
// Channel  Dir  tuser            tdata (from bit 0 up)
// s_axis   in   mode[1:0]        key_hash[63:0], payload[95:64]
// m_axis   out  status[2:0]      found_payload[31:0], live_count[38:32], zero pad
//
// Each slot probe is a read on the slot memory's registered read port, then a
// compare and write back. A find probes slots from the key's home slot on, then
// hands off the result and goes idle before the next transfer; an insert adds
// a placement walk after its probe, a remove a backward-shift walk.
// Input is taken only while idle; a stalled master holds the sequencer in its
// finish step. Reset clears occupancy at once, with no clearing pass.
// ============================================================================
module robin_hood_hash_table_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // key_hash, payload
    input  logic [1:0]   s_axis_tuser,   // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // found_payload, live_count
    output logic [2:0]   m_axis_tuser    // status
);
    import rhh_pkg::*;

    t_store_req        req;
    t_store_rsp        rsp;
    t_result           res;
    logic              take;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [PAY_W-1:0]  r_out_payload;
    logic [CNT_W-1:0]  r_out_count;

    assign take = !r_out_valid || m_axis_tready;

    rhh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_key      (s_axis_tdata[KEY_W-1:0]),
        .i_pay      (s_axis_tdata[KEY_W+PAY_W-1:KEY_W]),
        .o_res      (res),
        .i_res_take (take),
        .o_req      (req),
        .i_rsp      (rsp)
    );

    rhh_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_out_status  <= res.status;
            r_out_payload <= res.found_payload;
            r_out_count   <= res.live_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_payload};

endmodule
